FILE: rtl/sspu_pkg.sv
// sspu_pkg: shared types and constants of the sprite screen projection unit
// no dependencies

package sspu_pkg;

    localparam int POS_W   = 24;
    localparam int DIR_W   = 16;
    localparam int SCR_W   = 13;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    localparam int TY_W    = 55;
    localparam int SC_W    = 56;
    localparam int SIZE_W  = 29;

    localparam logic [POS_W-1:0]        PLAYER_X_RST   = 24'd0;
    localparam logic [POS_W-1:0]        PLAYER_Y_RST   = 24'd0;
    localparam logic signed [DIR_W-1:0] VIEW_DIR_X_RST = 16'sd16384;
    localparam logic signed [DIR_W-1:0] VIEW_DIR_Y_RST = 16'sd0;
    localparam logic signed [DIR_W-1:0] CAM_PLANE_X_RST = 16'sd0;
    localparam logic signed [DIR_W-1:0] CAM_PLANE_Y_RST = 16'sd10813;
    localparam logic [SCR_W-1:0]        SCREEN_W_RST   = 13'd640;
    localparam logic [SCR_W-1:0]        SCREEN_H_RST   = 13'd480;

    typedef enum logic [IDX_W-1:0] {
        REG_PLAYER_X    = 3'd0,
        REG_PLAYER_Y    = 3'd1,
        REG_VIEW_DIR_X  = 3'd2,
        REG_VIEW_DIR_Y  = 3'd3,
        REG_CAM_PLANE_X = 3'd4,
        REG_CAM_PLANE_Y = 3'd5,
        REG_SCREEN_W    = 3'd6,
        REG_SCREEN_H    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                   vis;
        logic [TY_W-1:0]        ty;
        logic signed [SC_W-1:0] sc;
    } side_t;

    typedef struct packed {
        logic               visible;
        logic [23:0]        depth;
        logic signed [15:0] center_x;
        logic [15:0]        sprite_size;
        logic [14:0]        start_x;
        logic signed [15:0] end_x;
        logic [11:0]        start_y;
        logic [11:0]        end_y;
    } res_t;

endpackage

FILE: rtl/sprite_screen_projection_unit.sv
// sprite_screen_projection_unit: projects sprite map positions through the camera
// depends on sspu_pkg and sspu_div
//
//  channel | signals                           | role
//  in      | in_valid in_stall sprite_x/y      | one sprite position per item
//  out     | out_valid out_stall visible..end_y| one projection per item
//  cfg     | cfg_we cfg_index cfg_data         | camera and screen registers
//
// one item per cycle while the skid register is empty; 4 front stages, 55 stages of
// the depth and centre dividers, 29 stages of the size divider, 2 back stages
// no clearing pass after reset; all valid bits clear at once
// an output register and a skid register part the sides; the pipeline holds
// only while the skid register is full

module sprite_screen_projection_unit
    import sspu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [23:0]        sprite_x,
    input  logic [23:0]        sprite_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               visible,
    output logic [23:0]        depth,
    output logic signed [15:0] center_x,
    output logic [15:0]        sprite_size,
    output logic [14:0]        start_x,
    output logic signed [15:0] end_x,
    output logic [11:0]        start_y,
    output logic [11:0]        end_y
);

    logic [POS_W-1:0]        player_x_reg, player_y_reg;
    logic signed [DIR_W-1:0] view_dir_x_reg, view_dir_y_reg;
    logic signed [DIR_W-1:0] cam_plane_x_reg, cam_plane_y_reg;
    logic [SCR_W-1:0]        screen_width_reg, screen_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg      <= PLAYER_X_RST;
            player_y_reg      <= PLAYER_Y_RST;
            view_dir_x_reg    <= VIEW_DIR_X_RST;
            view_dir_y_reg    <= VIEW_DIR_Y_RST;
            cam_plane_x_reg   <= CAM_PLANE_X_RST;
            cam_plane_y_reg   <= CAM_PLANE_Y_RST;
            screen_width_reg  <= SCREEN_W_RST;
            screen_height_reg <= SCREEN_H_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PLAYER_X:    player_x_reg      <= cfg_data[23:0];
                REG_PLAYER_Y:    player_y_reg      <= cfg_data[23:0];
                REG_VIEW_DIR_X:  view_dir_x_reg    <= $signed(cfg_data[15:0]);
                REG_VIEW_DIR_Y:  view_dir_y_reg    <= $signed(cfg_data[15:0]);
                REG_CAM_PLANE_X: cam_plane_x_reg   <= $signed(cfg_data[15:0]);
                REG_CAM_PLANE_Y: cam_plane_y_reg   <= $signed(cfg_data[15:0]);
                REG_SCREEN_W:    screen_width_reg  <= cfg_data[12:0];
                REG_SCREEN_H:    screen_height_reg <= cfg_data[12:0];
                default:         ;
            endcase
        end
    end

    logic en;
    logic skid_valid_reg, out_valid_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v6_reg;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // front stages: offsets, products, numerators, magnitudes
    logic signed [24:0] rx_reg, ry_reg;
    logic signed [40:0] dyrx_reg, dxry_reg, pxry_reg, pyrx_reg;
    logic signed [31:0] pxdy_reg, dxpy_reg;
    logic signed [41:0] nx_reg, ny_reg;
    logic signed [32:0] det_reg;
    logic [53:0]        mul_reg;
    logic [40:0]        abs_ny_reg;
    logic [31:0]        abs_det_reg;
    logic               vis_pre_reg, sc_neg_reg;

    logic signed [42:0] s_sum;
    logic [42:0]        s_mag;
    logic [41:0]        ny_mag;
    logic [32:0]        det_mag;

    assign s_sum   = 43'(nx_reg) + 43'(ny_reg);
    assign s_mag   = s_sum[42] ? 43'(-s_sum) : 43'(s_sum);
    assign ny_mag  = ny_reg[41] ? 42'(-ny_reg) : 42'(ny_reg);
    assign det_mag = det_reg[32] ? 33'(-det_reg) : 33'(det_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg      <= $signed({1'b0, sprite_x}) - $signed({1'b0, player_x_reg});
            ry_reg      <= $signed({1'b0, sprite_y}) - $signed({1'b0, player_y_reg});
            dyrx_reg    <= view_dir_y_reg * rx_reg;
            dxry_reg    <= view_dir_x_reg * ry_reg;
            pxry_reg    <= cam_plane_x_reg * ry_reg;
            pyrx_reg    <= cam_plane_y_reg * rx_reg;
            pxdy_reg    <= cam_plane_x_reg * view_dir_y_reg;
            dxpy_reg    <= view_dir_x_reg * cam_plane_y_reg;
            nx_reg      <= 42'(dyrx_reg) - 42'(dxry_reg);
            ny_reg      <= 42'(pxry_reg) - 42'(pyrx_reg);
            det_reg     <= 33'(pxdy_reg) - 33'(dxpy_reg);
            mul_reg     <= 54'(screen_width_reg[12:1]) * 54'(s_mag[41:0]);
            abs_ny_reg  <= ny_mag[40:0];
            abs_det_reg <= det_mag[31:0];
            vis_pre_reg <= (det_reg != '0) && (ny_reg[41] == det_reg[32]);
            sc_neg_reg  <= s_sum[42] ^ ny_reg[41];
        end
    end

    // depth and ratio dividers run in lockstep
    logic            a_valid, b_valid;
    logic [TY_W-1:0] a_quot, b_quot;
    logic            a_side, b_side;

    sspu_div #(.NW(TY_W), .DW(32), .SW(1)) u_div_depth (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_reg),
        .num({abs_ny_reg, 14'd0}), .den(abs_det_reg), .side_in(vis_pre_reg),
        .out_valid(a_valid), .quot(a_quot), .side_out(a_side)
    );

    sspu_div #(.NW(TY_W), .DW(41), .SW(1)) u_div_ratio (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_reg),
        .num({1'b0, mul_reg}), .den(abs_ny_reg), .side_in(sc_neg_reg),
        .out_valid(b_valid), .quot(b_quot), .side_out(b_side)
    );

    side_t              c_in, c_out;
    logic signed [SC_W-1:0] sc_mag;
    logic               c_valid;
    logic [SIZE_W-1:0]  c_quot;

    assign sc_mag  = $signed({1'b0, b_quot});
    assign c_in.vis = a_side && (a_quot != '0);
    assign c_in.ty  = a_quot;
    assign c_in.sc  = b_side ? -sc_mag : sc_mag;

    sspu_div #(.NW(SIZE_W), .DW(TY_W), .SW($bits(side_t))) u_div_size (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_valid),
        .num({screen_height_reg, 16'd0}), .den(a_quot), .side_in(c_in),
        .out_valid(c_valid), .quot(c_quot), .side_out(c_out)
    );

    // back stages: centre column, then bounds and saturation
    logic signed [56:0] cx_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [TY_W-1:0]    ty_reg;
    logic               vis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= c_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg   <= $signed({44'd0, screen_width_reg}) - 57'sd1 - 57'(c_out.sc);
            size_reg <= c_quot;
            ty_reg   <= c_out.ty;
            vis_reg  <= c_out.vis;
        end
    end

    logic signed [57:0] hs58, w58, sx, ex, ex_cl, cx58;
    logic signed [30:0] sy, ey, ey_cl, h31;
    res_t               res;

    always_comb
    begin
        cx58  = 58'(cx_reg);
        hs58  = $signed(58'(size_reg[SIZE_W-1:1]));
        w58   = $signed(58'(screen_width_reg));
        sx    = cx58 - hs58;
        ex    = cx58 + hs58;
        ex_cl = (ex >= w58) ? (w58 - 58'sd1) : ex;
        h31   = $signed(31'(screen_height_reg));
        sy    = $signed(31'(screen_height_reg[12:1])) - $signed(31'(size_reg[SIZE_W-1:1]));
        ey    = $signed(31'(screen_height_reg[12:1])) + $signed(31'(size_reg[SIZE_W-1:1]));
        ey_cl = (ey >= h31) ? (h31 - 31'sd1) : ey;

        res = '0;
        if (vis_reg)
        begin
            res.visible     = 1'b1;
            res.depth       = (ty_reg > 55'hFFFFFF) ? 24'hFFFFFF : ty_reg[23:0];
            res.center_x    = (cx_reg > 57'sd32767) ? 16'sh7FFF :
                              (cx_reg < -57'sd32768) ? 16'sh8000 : cx_reg[15:0];
            res.sprite_size = (size_reg > 29'd65535) ? 16'hFFFF : size_reg[15:0];
            res.start_x     = (sx < 58'sd0) ? 15'd0 :
                              (sx > 58'sd32767) ? 15'h7FFF : sx[14:0];
            res.end_x       = (ex_cl > 58'sd32767) ? 16'sh7FFF :
                              (ex_cl < -58'sd32768) ? 16'sh8000 : ex_cl[15:0];
            res.start_y     = (sy < 31'sd0) ? 12'd0 :
                              (sy > 31'sd4095) ? 12'hFFF : sy[11:0];
            res.end_y       = (ey_cl < 31'sd0) ? 12'd0 :
                              (ey_cl > 31'sd4095) ? 12'hFFF : ey_cl[11:0];
        end
    end

    // output register and skid register
    res_t out_reg, skid_reg;
    logic out_take, load_from_skid, load_from_pipe, load_skid;

    assign out_take       = out_valid_reg && !out_stall;
    assign load_from_skid = skid_valid_reg && out_take;
    assign load_from_pipe = en && v6_reg && (!out_valid_reg || out_take);
    assign load_skid      = en && v6_reg && out_valid_reg && !out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_from_skid)
                skid_valid_reg <= 1'b0;
            else if (load_skid)
                skid_valid_reg <= 1'b1;

            if (load_from_skid || load_from_pipe)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
            out_reg <= skid_reg;
        else if (load_from_pipe)
            out_reg <= res;
        if (load_skid)
            skid_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign visible     = out_reg.visible;
    assign depth       = out_reg.depth;
    assign center_x    = out_reg.center_x;
    assign sprite_size = out_reg.sprite_size;
    assign start_x     = out_reg.start_x;
    assign end_x       = out_reg.end_x;
    assign start_y     = out_reg.start_y;
    assign end_y       = out_reg.end_y;

`ifndef SYNTH
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid == b_valid)
        else $error("depth and ratio dividers out of step");

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (depth == '0 && sprite_size == '0 && end_x == '0))
        else $error("hidden item carries nonzero fields");

    a_visible_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && visible) |-> (depth != '0))
        else $error("visible item with zero depth");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> !skid_valid_reg)
        else $error("skid register did not drain");
`endif

endmodule

FILE: rtl/sspu_div.sv
// sspu_div: pipelined unsigned restoring divider, one quotient bit per stage
// no dependencies; a side payload travels along with each item

module sspu_div #(
    parameter int NW = 55,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quot,
    output logic [SW-1:0] side_out
);

    logic [NW-1:0] vld_reg;
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic          vld_prev;
        logic [NW-1:0] nq_prev;
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] den_prev;
        logic [SW-1:0] side_prev;
        logic [DW:0]   shifted;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign nq_prev   = num;
            assign rem_prev  = '0;
            assign den_prev  = den;
            assign side_prev = side_in;
        end
        else
        begin : g_next
            assign vld_prev  = vld_reg[i-1];
            assign nq_prev   = nq_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign den_prev  = den_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign shifted = {rem_prev, nq_prev[NW-1]};
        assign diff    = shifted - {1'b0, den_prev};
        assign ge      = (shifted >= {1'b0, den_prev});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[i]   <= {nq_prev[NW-2:0], ge};
                rem_reg[i]  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
                den_reg[i]  <= den_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quot      = nq_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule
